// ===== design/cnp_pkg.sv =====
// ----------------------------------------------------------------------------
// cnp_pkg
// Types, constants and saturating arithmetic helpers for the numeral parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cnp_pkg;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned ValueW = 64;
  localparam int unsigned DigitW = 4;

  localparam logic [ValueW-1:0] AllOnes = {ValueW{1'b1}};

  localparam logic [ValueW-1:0] KTen      = 64'd10;
  localparam logic [ValueW-1:0] KHundred  = 64'd100;
  localparam logic [ValueW-1:0] KThousand = 64'd1000;
  localparam logic [ValueW-1:0] KWan      = 64'd10000;
  localparam logic [ValueW-1:0] KYi       = 64'd100000000;

  localparam logic [ValueW-1:0] LimTen      = AllOnes / KTen;
  localparam logic [ValueW-1:0] LimHundred  = AllOnes / KHundred;
  localparam logic [ValueW-1:0] LimThousand = AllOnes / KThousand;
  localparam logic [ValueW-1:0] LimWan      = AllOnes / KWan;
  localparam logic [ValueW-1:0] LimYi       = AllOnes / KYi;

  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_DIGIT,
    KIND_SMALL,
    KIND_WAN,
    KIND_YI
  } kind_e;

  typedef enum logic [2:0] {
    UNIT_TEN,
    UNIT_HUNDRED,
    UNIT_THOUSAND,
    UNIT_WAN,
    UNIT_YI
  } unit_e;

  typedef struct packed {
    kind_e             kind;
    logic [DigitW-1:0] digit;
    unit_e             unit;
    logic              last;
  } cls_t;

  typedef struct packed {
    logic              ovf;
    logic [ValueW-1:0] val;
  } sat_t;

  typedef struct packed {
    logic [ValueW-1:0] pend;
    logic [ValueW-1:0] part;
    logic [ValueW-1:0] high;
    logic              err;
    logic              ovf;
  } acc_t;

  function automatic sat_t add_sat(input logic [ValueW-1:0] a, input logic [ValueW-1:0] b);
    logic [ValueW:0] sum;
    sat_t            r;
    sum   = {1'b0, a} + {1'b0, b};
    r.ovf = sum[ValueW];
    r.val = sum[ValueW] ? AllOnes : sum[ValueW-1:0];
    return r;
  endfunction

  function automatic sat_t mul_sat(input logic [ValueW-1:0] a, input unit_e u);
    logic [ValueW-1:0] lim;
    logic [ValueW-1:0] prod;
    sat_t              r;
    unique case (u)
      UNIT_TEN: begin
        lim  = LimTen;
        prod = a * KTen;
      end
      UNIT_HUNDRED: begin
        lim  = LimHundred;
        prod = a * KHundred;
      end
      UNIT_THOUSAND: begin
        lim  = LimThousand;
        prod = a * KThousand;
      end
      UNIT_WAN: begin
        lim  = LimWan;
        prod = a * KWan;
      end
      UNIT_YI: begin
        lim  = LimYi;
        prod = a * KYi;
      end
      default: begin
        lim  = AllOnes;
        prod = a;
      end
    endcase
    r.ovf = a > lim;
    r.val = r.ovf ? AllOnes : prod;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/cnp_in_if.sv =====
// ----------------------------------------------------------------------------
// cnp_in_if
// Character channel: one code point per item with an end-of-numeral mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cnp_in_if
  import cnp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CodeW-1:0]  code_point;
  logic              last_char;

  modport source (output valid, output code_point, output last_char, input ready);
  modport sink (input valid, input code_point, input last_char, output ready);
endinterface

`default_nettype wire

// ===== design/cnp_out_if.sv =====
// ----------------------------------------------------------------------------
// cnp_out_if
// Result channel: parsed value with error and overflow flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cnp_out_if
  import cnp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              bad_char;
  logic              overflow;

  modport source (output valid, output value, output bad_char, output overflow, input ready);
  modport sink (input valid, input value, input bad_char, input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/cnp_front.sv =====
// ----------------------------------------------------------------------------
// cnp_front
// Accepts characters and classifies each into kind, digit and unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnp_front
  import cnp_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CodeW-1:0] code_point_i,
  input  logic             last_char_i,
  input  logic             q_full_i,
  output logic             push_o,
  output cls_t             cls_o
);

  always_comb begin
    cls_o.kind  = KIND_DIGIT;
    cls_o.digit = '0;
    cls_o.unit  = UNIT_TEN;
    cls_o.last  = last_char_i;
    unique case (code_point_i)
      16'h96F6:          cls_o.digit = 4'd0;
      16'h4E00, 16'h58F9: cls_o.digit = 4'd1;
      16'h4E8C, 16'h8D30: cls_o.digit = 4'd2;
      16'h4E09, 16'h53C1: cls_o.digit = 4'd3;
      16'h56DB, 16'h8086: cls_o.digit = 4'd4;
      16'h4E94, 16'h4F0D: cls_o.digit = 4'd5;
      16'h516D, 16'h9646: cls_o.digit = 4'd6;
      16'h4E03, 16'h67D2: cls_o.digit = 4'd7;
      16'h516B, 16'h634C: cls_o.digit = 4'd8;
      16'h4E5D, 16'h7396: cls_o.digit = 4'd9;
      16'h5341, 16'h62FE: begin
        cls_o.kind = KIND_SMALL;
        cls_o.unit = UNIT_TEN;
      end
      16'h767E, 16'h4F70: begin
        cls_o.kind = KIND_SMALL;
        cls_o.unit = UNIT_HUNDRED;
      end
      16'h5343, 16'h4EDF: begin
        cls_o.kind = KIND_SMALL;
        cls_o.unit = UNIT_THOUSAND;
      end
      16'h4E07, 16'h842C: begin
        cls_o.kind = KIND_WAN;
        cls_o.unit = UNIT_WAN;
      end
      16'h4EBF, 16'h5104: begin
        cls_o.kind = KIND_YI;
        cls_o.unit = UNIT_YI;
      end
      default:           cls_o.kind = KIND_BAD;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

// ===== design/cnp_queue.sv =====
// ----------------------------------------------------------------------------
// cnp_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnp_queue
  import cnp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cls_t pop_data_o
);

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = cnt_q[1];
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== design/cnp_back.sv =====
// ----------------------------------------------------------------------------
// cnp_back
// Applies classified characters to the accumulators and forms the total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnp_back
  import cnp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cls_t              q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] value_o,
  output logic              bad_char_o,
  output logic              overflow_o
);

  acc_t              acc_q, acc_d;
  acc_t              fin_q;
  logic              fin_valid_q;
  logic              fin_adv;
  logic              out_valid_q;
  logic [ValueW-1:0] value_q;
  logic              bad_q;
  logic              ovf_q;

  sat_t              t1, t2, t3, t4;
  logic [ValueW-1:0] run;
  sat_t              f1, f2;
  logic [ValueW-1:0] tot_val;
  logic              tot_ovf;

  always_comb begin
    acc_d = acc_q;
    run   = (acc_q.pend == '0) ? 64'd1 : acc_q.pend;
    t1    = '0;
    t2    = '0;
    t3    = '0;
    t4    = '0;
    if (!acc_q.err) begin
      unique case (q_data_i.kind)
        KIND_DIGIT: begin
          t1 = mul_sat(acc_q.pend, UNIT_TEN);
          t2 = add_sat(t1.val, {{(ValueW-DigitW){1'b0}}, q_data_i.digit});
          acc_d.pend = t2.val;
          acc_d.ovf  = acc_q.ovf | t1.ovf | t2.ovf;
        end
        KIND_SMALL: begin
          t1 = mul_sat(run, q_data_i.unit);
          t2 = add_sat(acc_q.part, t1.val);
          acc_d.part = t2.val;
          acc_d.pend = '0;
          acc_d.ovf  = acc_q.ovf | t1.ovf | t2.ovf;
        end
        KIND_WAN: begin
          t1 = add_sat(acc_q.part, acc_q.pend);
          t2 = mul_sat(t1.val, UNIT_WAN);
          acc_d.part = t2.val;
          acc_d.pend = '0;
          acc_d.ovf  = acc_q.ovf | t1.ovf | t2.ovf;
        end
        KIND_YI: begin
          t1 = add_sat(acc_q.part, acc_q.pend);
          t2 = mul_sat(t1.val, UNIT_YI);
          t3 = mul_sat(acc_q.high, UNIT_YI);
          t4 = add_sat(t3.val, t2.val);
          acc_d.high = t4.val;
          acc_d.part = '0;
          acc_d.pend = '0;
          acc_d.ovf  = acc_q.ovf | t1.ovf | t2.ovf | t3.ovf | t4.ovf;
        end
        default: acc_d.err = 1'b1;
      endcase
    end
  end

  assign fin_adv = fin_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o   = q_valid_i && (!q_data_i.last || !fin_valid_q || fin_adv);

  always_comb begin
    f1      = add_sat(fin_q.part, fin_q.pend);
    f2      = add_sat(f1.val, fin_q.high);
    tot_ovf = fin_q.ovf;
    tot_val = '0;
    if (!fin_q.err) begin
      tot_ovf = fin_q.ovf | f1.ovf | f2.ovf;
      tot_val = tot_ovf ? AllOnes : f2.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        acc_q <= q_data_i.last ? '0 : acc_d;
      end
      if (pop_o && q_data_i.last) begin
        fin_valid_q <= 1'b1;
      end else if (fin_adv) begin
        fin_valid_q <= 1'b0;
      end
      if (fin_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_data_i.last) begin
      fin_q <= acc_d;
    end
    if (fin_adv) begin
      value_q <= tot_val;
      bad_q   <= fin_q.err;
      ovf_q   <= tot_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign bad_char_o  = bad_q;
  assign overflow_o  = ovf_q;

endmodule

`default_nettype wire

// ===== design/chinese_numeral_to_integer.sv =====
// ----------------------------------------------------------------------------
// chinese_numeral_to_integer
// Parses a stream of numeral characters into a 64-bit unsigned value.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one code point per item; last_char marks the final
//   character of a numeral. out_o carries one item per numeral: the value,
//   bad_char for an unknown character (value 0) and overflow (value all ones).
//   Items that are not last produce no result.
// Timing:
//   One character per cycle sustained until a held out_o fills the queue. The
//   front classifies and writes a two-entry queue; the back applies one queued
//   character per cycle through constant multiplies and saturating adds.
//   A last character's accumulator update is registered in the final-sum stage,
//   whose sum is then registered in the result register that out_o offers.
// Reset:
//   rst_ni clears the queue count and pointers, the accumulators and the
//   result valid flag; the result data is not reset. Stall:
//   While out_o is held, the finished numeral waits in the final-sum stage;
//   characters of the next numeral keep flowing until its last character
//   needs that stage, then the queue fills and in_i.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chinese_numeral_to_integer
  import cnp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cnp_in_if.sink    in_i,
  cnp_out_if.source out_o
);

  logic q_full;
  logic push;
  cls_t push_data;
  logic pop;
  logic q_valid;
  cls_t q_data;

  cnp_front u_front (
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .code_point_i (in_i.code_point),
    .last_char_i  (in_i.last_char),
    .q_full_i     (q_full),
    .push_o       (push),
    .cls_o        (push_data)
  );

  cnp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  cnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .value_o     (out_o.value),
    .bad_char_o  (out_o.bad_char),
    .overflow_o  (out_o.overflow)
  );

endmodule

`default_nettype wire
